FILE: rtl/core/pncs_pkg.sv
// shared types, constants and helpers of the palette nearest color search
package pncs_pkg;

    localparam int CHAN_W  = 8;
    localparam int INDEX_W = 8;
    localparam int SQ_W    = 2 * CHAN_W;
    localparam int DIST_W  = SQ_W + 2;
    localparam int COLOR_W = 3 * CHAN_W;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // classified command handed from front to back
    typedef struct packed {
        logic               search;
        logic [INDEX_W-1:0] entry_index;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
    } cmd_t;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

endpackage

FILE: rtl/core/pncs_req_if.sv
// request channel: palette write and search items
interface pncs_req_if
    import pncs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [INDEX_W-1:0] entry_index;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;

    modport source (output valid, opcode, entry_index, red, green, blue, input ready);
    modport sink   (input valid, opcode, entry_index, red, green, blue, output ready);
endinterface

FILE: rtl/core/pncs_rsp_if.sv
// response channel: nearest palette index
interface pncs_rsp_if
    import pncs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] nearest_index;

    modport source (output valid, nearest_index, input ready);
    modport sink   (input valid, nearest_index, output ready);
endinterface

FILE: rtl/core/pncs_ram.sv
// generic single-write, single-read RAM with registered read data
module pncs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/core/pncs_front.sv
// front end: accepts request items, drops out-of-range writes, queues commands
module pncs_front
    import pncs_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    pncs_req_if.sink   req,
    output logic       q_vld,
    output cmd_t       q_cmd,
    input  logic       q_pop
);
    cmd_t               ent_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               accept;
    logic               in_range;
    logic               push;
    logic               pop;
    cmd_t               cmd_in;

    assign req.ready = (cnt_reg != Q_CNT_W'(Q_DEPTH));
    assign accept    = req.valid && req.ready;
    // writes past the end of the palette have no effect at all
    assign in_range  = ({1'b0, req.entry_index} < (INDEX_W + 1)'(PALETTE_ENTRIES));
    assign push      = accept && ((req.opcode == OP_SEARCH) || in_range);
    assign pop       = q_pop && (cnt_reg != '0);

    always_comb
    begin
        cmd_in.search      = (req.opcode == OP_SEARCH);
        cmd_in.entry_index = req.entry_index;
        cmd_in.red         = req.red;
        cmd_in.green       = req.green;
        cmd_in.blue        = req.blue;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign q_vld = (cnt_reg != '0);
    assign q_cmd = ent_reg[rd_ptr_reg];
endmodule

FILE: rtl/core/pncs_back.sv
// back end: palette store, pipelined distance scan and result register
module pncs_back
    import pncs_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_vld,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    pncs_rsp_if.source  rsp
);
    localparam int IDX_W = $clog2(PALETTE_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   sc_cnt_reg, sc_cnt_next;
    logic [CHAN_W-1:0]  key_r_reg, key_g_reg, key_b_reg;
    logic               key_load;
    logic               ram_we;
    logic               rd_issue;
    logic               load_out;
    logic [COLOR_W-1:0] rdata;
    logic [COLOR_W-1:0] entry;
    logic               ent_vld_reg [PALETTE_ENTRIES];

    logic               s1_vld_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic               s1_ev_reg;
    logic               s2_vld_reg;
    logic [IDX_W-1:0]   s2_idx_reg;
    logic [SQ_W-1:0]    sq_r_reg, sq_g_reg, sq_b_reg;
    logic [DIST_W-1:0]  dist_sum;
    logic               better;
    logic [DIST_W-1:0]  best_dist_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic               out_vld_reg, out_vld_next;
    logic [INDEX_W-1:0] out_idx_reg;

    pncs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (q_cmd.entry_index[IDX_W-1:0]),
        .wdata ({q_cmd.red, q_cmd.green, q_cmd.blue}),
        .re    (rd_issue),
        .raddr (sc_cnt_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        sc_cnt_next = sc_cnt_reg;
        q_pop       = 1'b0;
        ram_we      = 1'b0;
        key_load    = 1'b0;
        rd_issue    = 1'b0;
        load_out    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_vld)
                begin
                    q_pop = 1'b1;
                    if (q_cmd.search)
                    begin
                        key_load    = 1'b1;
                        sc_cnt_next = '0;
                        state_next  = ST_SCAN;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                rd_issue = 1'b1;
                if (sc_cnt_reg == IDX_W'(PALETTE_ENTRIES - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    sc_cnt_next = sc_cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_vld_reg && !s2_vld_reg && (!out_vld_reg || rsp.ready))
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // entries never written read as black
    assign entry    = s1_ev_reg ? rdata : '0;
    assign dist_sum = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
    assign better   = (s2_idx_reg == '0) || (dist_sum < best_dist_reg);

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (load_out)
        begin
            out_vld_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            sc_cnt_reg  <= '0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int i = 0; i < PALETTE_ENTRIES; i++)
            begin
                ent_vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            sc_cnt_reg  <= sc_cnt_next;
            s1_vld_reg  <= rd_issue;
            s2_vld_reg  <= s1_vld_reg;
            out_vld_reg <= out_vld_next;
            if (ram_we)
            begin
                ent_vld_reg[q_cmd.entry_index[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_load)
        begin
            key_r_reg <= q_cmd.red;
            key_g_reg <= q_cmd.green;
            key_b_reg <= q_cmd.blue;
        end
        s1_idx_reg <= sc_cnt_reg;
        s1_ev_reg  <= ent_vld_reg[sc_cnt_reg];
        s2_idx_reg <= s1_idx_reg;
        sq_r_reg   <= sq_diff(key_r_reg, entry[COLOR_W-1 -: CHAN_W]);
        sq_g_reg   <= sq_diff(key_g_reg, entry[2*CHAN_W-1 -: CHAN_W]);
        sq_b_reg   <= sq_diff(key_b_reg, entry[CHAN_W-1:0]);
        if (s2_vld_reg && better)
        begin
            best_dist_reg <= dist_sum;
            best_idx_reg  <= s2_idx_reg;
        end
        if (load_out)
        begin
            out_idx_reg <= INDEX_W'(best_idx_reg);
        end
    end

    assign rsp.valid         = out_vld_reg;
    assign rsp.nearest_index = out_idx_reg;
endmodule

FILE: rtl/core/palette_nearest_color_search.sv
// top level of the palette nearest color search
//
// keeps a palette of PALETTE_ENTRIES rgb entries, all black after reset, and
// answers search items with the lowest index of the entry at least squared
// euclidean distance. a write item (opcode 0) stores red, green and blue at
// entry_index and gives no response; writes at or past PALETTE_ENTRIES are
// dropped. a search item (opcode 1) gives exactly one response item, in order
// with all earlier items. the front end takes items into a two-deep command
// queue, so the request side keeps moving until the queue is full while the
// back end is busy; the back end runs one command at a time. a write is
// stored into the palette when it leaves the queue; a search reads the one
// palette read port once per entry in index order, lets the read, square and
// compare pipeline drain and loads the result once the output register is
// free. the response sits in an output register so the next command can
// start while it waits. no clearing pass is needed: per-entry valid flops
// make unwritten entries read as black from the first cycle after reset.
module palette_nearest_color_search
    import pncs_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    pncs_req_if.sink   req,
    pncs_rsp_if.source rsp
);
    // command queue between front and back
    logic q_vld;
    logic q_pop;
    cmd_t q_cmd;

    pncs_front #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .q_vld (q_vld),
        .q_cmd (q_cmd),
        .q_pop (q_pop)
    );

    // palette store, distance scan and response register
    pncs_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .q_vld (q_vld),
        .q_cmd (q_cmd),
        .q_pop (q_pop),
        .rsp   (rsp)
    );
endmodule
